>>> hdl/plm_pkg.sv
`default_nettype none

package plm_pkg;

  // defaults for the top-level parameters
  localparam int unsigned TableSizeDef = 256;
  localparam int unsigned MaxPointsDef = 8;

  // field widths
  localparam int unsigned IdxW   = 8;
  localparam int unsigned PosW   = 9;
  localparam int unsigned SlotW  = 3;
  localparam int unsigned CompW  = 8;
  localparam int unsigned ColorW = 3 * CompW;
  localparam int unsigned CountW = 4;

  // interpolation datapath widths
  localparam int unsigned NumW  = PosW + CompW;
  localparam int unsigned DvsW  = PosW + 1;
  localparam int unsigned DvdW  = DvsW + CompW;
  localparam int unsigned StepW = $clog2(CompW);

  // register port
  localparam int unsigned PaddrW  = 3;
  localparam int unsigned PdataW  = 32;
  localparam int unsigned RegIdxW = 1;

  localparam logic [RegIdxW-1:0] RegPointCount = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegGrayMode   = RegIdxW'(1);

  localparam logic [CountW-1:0] CountRst = CountW'(2);
  localparam logic [CountW-1:0] MinCount = CountW'(2);

  // transaction kinds
  localparam logic KindLoad   = 1'b0;
  localparam logic KindLookup = 1'b1;

  // color component being interpolated
  localparam logic [1:0] CompRed   = 2'd0;
  localparam logic [1:0] CompGreen = 2'd1;
  localparam logic [1:0] CompBlue  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHK_LAST,
    ST_CHK_FIRST,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } plm_state_e;

endpackage

`default_nettype wire

>>> hdl/plm_if.sv
`default_nettype none

interface plm_in_if;
  import plm_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [SlotW-1:0]  slot;
  logic [PosW-1:0]   position;
  logic [CompW-1:0]  point_red;
  logic [CompW-1:0]  point_green;
  logic [CompW-1:0]  point_blue;
  logic [IdxW-1:0]   index;

  modport source (
    output valid, kind, slot, position, point_red, point_green, point_blue, index,
    input  ready
  );
  modport sink (
    input  valid, kind, slot, position, point_red, point_green, point_blue, index,
    output ready
  );
endinterface

interface plm_out_if;
  import plm_pkg::*;

  logic             valid;
  logic             ready;
  logic [CompW-1:0] red;
  logic [CompW-1:0] green;
  logic [CompW-1:0] blue;

  modport source (
    output valid, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue,
    output ready
  );
endinterface

`default_nettype wire

>>> hdl/plm_ram.sv
`default_nettype none

module plm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hdl/plm_div.sv
`default_nettype none

module plm_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [plm_pkg::DvdW-1:0]  dividend_i,
  input  logic [plm_pkg::DvsW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [plm_pkg::CompW-1:0] quot_o
);
  import plm_pkg::*;

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [DvsW-1:0]  rem_q, rem_d;
  logic [DvsW-1:0]  dvs_q, dvs_d;
  logic [CompW-1:0] lo_q, lo_d;
  logic [CompW-1:0] quot_q, quot_d;

  // one restoring step: bring down a dividend bit, trial subtract
  logic [DvsW:0] trial_c;
  logic          ge_c;

  assign trial_c = {rem_q, lo_q[CompW-1]};
  assign ge_c    = (trial_c >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    lo_d   = lo_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = dividend_i[DvdW-1:CompW];
      lo_d   = dividend_i[CompW-1:0];
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge_c ? DvsW'(trial_c - {1'b0, dvs_q}) : trial_c[DvsW-1:0];
      quot_d = {quot_q[CompW-2:0], ge_c};
      lo_d   = {lo_q[CompW-2:0], 1'b0};
      cnt_d  = cnt_q + StepW'(1);
      if (cnt_q == StepW'(CompW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    lo_q   <= lo_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

>>> hdl/piecewise_linear_colormap.sv
// Piecewise linear colormap. A load transaction (kind 0) stores a control point (table
// position and RGB color) in a slot and returns nothing. A lookup transaction
// (kind 1) returns one color: in gray mode (index, index, index) in the cycle after accept;
// otherwise a sequencer reads the point store one entry per cycle (last point, first point,
// then a segment scan), and a shared 8-step restoring divider forms each component as
// round-half-up of (c0*(L-d) + c1*d) / L, one component after another. A control-point lookup
// runs an end check on the last point and, if that does not settle it, on the first point,
// then a segment scan and, when a segment holds the index, an interpolation of each component
// in turn by the divider; the input is not ready until the result has been taken. Registers
// at byte 0 (point_count, clamped to 2..MAX_POINTS) and byte 4 (gray_mode, reset 1) are to be
// written by the user only while no lookup is in flight; the block does not enforce this.
// Points must be loaded before a lookup reads them.

`default_nettype none

module piecewise_linear_colormap #(
  parameter int unsigned TABLE_SIZE = plm_pkg::TableSizeDef,
  parameter int unsigned MAX_POINTS = plm_pkg::MaxPointsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [plm_pkg::PaddrW-1:0] paddr,
  input  logic [plm_pkg::PdataW-1:0] pwdata,
  output logic [plm_pkg::PdataW-1:0] prdata,
  output logic                       pready,
  plm_in_if.sink                     item_i,
  plm_out_if.source                  color_o
);
  import plm_pkg::*;

  localparam int unsigned AddrW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned LastIdx = TABLE_SIZE - 1;
  localparam int unsigned EntryW  = PosW + ColorW;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic [CountW-1:0]  count_q;
  logic               gray_q;
  logic [RegIdxW-1:0] reg_idx_c;
  logic               cfg_we_c;

  assign pready    = 1'b1;
  assign reg_idx_c = paddr[PaddrW-1:2];
  assign cfg_we_c  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountRst;
      gray_q  <= 1'b1;
    end else if (cfg_we_c) begin
      case (reg_idx_c)
        RegPointCount: count_q <= pwdata[CountW-1:0];
        RegGrayMode:   gray_q  <= pwdata[0];
        default:       ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_c)
      RegPointCount: prdata = PdataW'(count_q);
      RegGrayMode:   prdata = PdataW'(gray_q);
      default:       prdata = '0;
    endcase
  end

  // number of points in use, clamped, and the slot of the last one
  logic [CountW:0]  n_c;
  logic [AddrW-1:0] last_c;

  always_comb begin
    if (count_q < MinCount) begin
      n_c = (CountW+1)'(MinCount);
    end else if ({1'b0, count_q} > (CountW+1)'(MAX_POINTS)) begin
      n_c = (CountW+1)'(MAX_POINTS);
    end else begin
      n_c = {1'b0, count_q};
    end
  end

  assign last_c = AddrW'(n_c - (CountW+1)'(1));

  // ---------------------------------------------------------------------------
  // point store: {position, red, green, blue} per slot, registered read
  // ---------------------------------------------------------------------------
  logic              ram_we_c;
  logic [AddrW-1:0]  ram_raddr_c;
  logic [EntryW-1:0] ram_rdata;
  logic [PosW-1:0]   rd_pos_c;
  logic [ColorW-1:0] rd_col_c;
  logic              slot_ok_c;

  assign slot_ok_c = (32'(item_i.slot) < MAX_POINTS);
  assign rd_pos_c  = ram_rdata[EntryW-1 -: PosW];
  assign rd_col_c  = ram_rdata[ColorW-1:0];

  plm_ram #(
    .Width (EntryW),
    .Depth (MAX_POINTS)
  ) u_plm_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we_c),
    .waddr_i (AddrW'(item_i.slot)),
    .wdata_i ({item_i.position, item_i.point_red, item_i.point_green, item_i.point_blue}),
    .raddr_i (ram_raddr_c),
    .rdata_o (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // sequencer state and working registers
  // ---------------------------------------------------------------------------
  plm_state_e state_q, state_d;

  logic [IdxW-1:0]   idx_q;
  logic [AddrW-1:0]  addr_q;
  logic [PosW-1:0]   prev_pos_q;
  logic [ColorW-1:0] prev_col_q;
  logic [ColorW-1:0] clast_q;
  logic [ColorW-1:0] c1_q;
  logic [PosW-1:0]   len_q;
  logic [PosW-1:0]   d_q;
  logic [1:0]        comp_q;
  logic [ColorW-1:0] res_q;

  // index clamped to the table
  logic [IdxW-1:0] idx_c;
  assign idx_c = (32'(item_i.index) > LastIdx) ? IdxW'(LastIdx) : item_i.index;

  // compares against the entry just read
  logic [PosW-1:0] idx9_c;
  logic            is_end_c;
  logic            ge_rd_c;
  logic            hit_c;
  logic            in_acc_c;

  assign idx9_c   = PosW'(idx_q);
  assign is_end_c = (32'(idx_q) == LastIdx);
  assign ge_rd_c  = (idx9_c >= rd_pos_c);
  assign hit_c    = (prev_pos_q <= idx9_c) && (idx9_c < rd_pos_c);
  assign in_acc_c = item_i.valid & item_i.ready;

  // ---------------------------------------------------------------------------
  // interpolation: numerator for the current component, then the shared divider
  // ---------------------------------------------------------------------------
  logic [CompW-1:0] c0_c, c1_c;
  logic [NumW-1:0]  prod0_c, prod1_c, num_c;
  logic [DvdW-1:0]  dvd_c;
  logic [DvsW-1:0]  dvs_c;
  logic             div_start_c;
  logic             div_done;
  logic [CompW-1:0] div_quot;

  always_comb begin
    case (comp_q)
      CompRed: begin
        c0_c = prev_col_q[3*CompW-1 -: CompW];
        c1_c = c1_q[3*CompW-1 -: CompW];
      end
      CompGreen: begin
        c0_c = prev_col_q[2*CompW-1 -: CompW];
        c1_c = c1_q[2*CompW-1 -: CompW];
      end
      default: begin
        c0_c = prev_col_q[CompW-1:0];
        c1_c = c1_q[CompW-1:0];
      end
    endcase
  end

  // round half up: (2*num + L) / (2*L)
  assign prod0_c = NumW'(c0_c) * NumW'(len_q - d_q);
  assign prod1_c = NumW'(c1_c) * NumW'(d_q);
  assign num_c   = prod0_c + prod1_c;
  assign dvd_c   = {num_c, 1'b0} + DvdW'(len_q);
  assign dvs_c   = {len_q, 1'b0};

  plm_div u_plm_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start_c),
    .dividend_i (dvd_c),
    .divisor_i  (dvs_c),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (item_i.valid && (item_i.kind == KindLookup)) begin
          state_d = gray_q ? ST_OUT : ST_CHK_LAST;
        end
      end
      // entry of the last point is on the read port
      ST_CHK_LAST:  state_d = (is_end_c || ge_rd_c) ? ST_OUT : ST_CHK_FIRST;
      // entry of point 0 is on the read port
      ST_CHK_FIRST: state_d = ge_rd_c ? ST_SCAN : ST_OUT;
      // entry addr_q is on the read port, entry addr_q-1 is held in prev
      ST_SCAN: begin
        if (hit_c) begin
          state_d = ST_MUL;
        end else if (addr_q == last_c) begin
          state_d = ST_OUT;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: begin
        if (div_done) begin
          state_d = (comp_q == CompBlue) ? ST_OUT : ST_MUL;
        end
      end
      ST_OUT: begin
        if (color_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    item_i.ready = 1'b0;
    color_o.valid = 1'b0;
    ram_we_c     = 1'b0;
    ram_raddr_c  = '0;
    div_start_c  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        ram_we_c     = item_i.valid & (item_i.kind == KindLoad) & slot_ok_c;
        // prefetch the last point so it is ready the cycle after accept
        ram_raddr_c  = last_c;
      end
      ST_CHK_LAST:  ram_raddr_c = '0;
      ST_CHK_FIRST: ram_raddr_c = AddrW'(1);
      ST_SCAN:      ram_raddr_c = addr_q + AddrW'(1);
      ST_MUL:       div_start_c = 1'b1;
      ST_OUT:       color_o.valid = 1'b1;
      default:      ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_acc_c && (item_i.kind == KindLookup)) begin
          idx_q <= idx_c;
          res_q <= {idx_c, idx_c, idx_c};
        end
      end
      ST_CHK_LAST: begin
        clast_q <= rd_col_c;
        res_q   <= rd_col_c;
      end
      ST_CHK_FIRST: begin
        res_q      <= rd_col_c;
        prev_pos_q <= rd_pos_c;
        prev_col_q <= rd_col_c;
        addr_q     <= AddrW'(1);
      end
      ST_SCAN: begin
        if (hit_c) begin
          c1_q   <= rd_col_c;
          len_q  <= rd_pos_c - prev_pos_q;
          d_q    <= idx9_c - prev_pos_q;
          comp_q <= CompRed;
        end else if (addr_q == last_c) begin
          // no segment holds the index
          res_q <= clast_q;
        end else begin
          prev_pos_q <= rd_pos_c;
          prev_col_q <= rd_col_c;
          addr_q     <= addr_q + AddrW'(1);
        end
      end
      ST_DIV: begin
        if (div_done) begin
          case (comp_q)
            CompRed:   res_q[3*CompW-1 -: CompW] <= div_quot;
            CompGreen: res_q[2*CompW-1 -: CompW] <= div_quot;
            default:   res_q[CompW-1:0]          <= div_quot;
          endcase
          comp_q <= comp_q + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign color_o.red   = res_q[3*CompW-1 -: CompW];
  assign color_o.green = res_q[2*CompW-1 -: CompW];
  assign color_o.blue  = res_q[CompW-1:0];

endmodule

`default_nettype wire

>>> hdl/plm_chk.sv
`default_nettype none

module plm_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_ready_i,
  input logic                      in_kind_i,
  input logic                      out_valid_i,
  input logic                      out_ready_i,
  input logic [plm_pkg::CompW-1:0] out_red_i,
  input logic [plm_pkg::CompW-1:0] out_green_i,
  input logic [plm_pkg::CompW-1:0] out_blue_i
);
  import plm_pkg::*;

  // one lookup at a time: no new transaction while a result is pending
  a_no_accept_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i)
    else $error("input ready while a result is pending");

  // a lookup closes the input for at least the next cycle
  a_lookup_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KindLookup)) |=> !in_ready_i)
    else $error("input still ready after a lookup");

  // a load produces no result and the input is ready again in the next cycle
  a_load_single_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i && (in_kind_i == KindLoad)) |=> (in_ready_i && !out_valid_i))
    else $error("load did not complete in one cycle");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(out_red_i) && $stable(out_green_i) && $stable(out_blue_i)))
    else $error("result changed while stalled");

endmodule

bind piecewise_linear_colormap plm_chk u_plm_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (item_i.valid),
  .in_ready_i  (item_i.ready),
  .in_kind_i   (item_i.kind),
  .out_valid_i (color_o.valid),
  .out_ready_i (color_o.ready),
  .out_red_i   (color_o.red),
  .out_green_i (color_o.green),
  .out_blue_i  (color_o.blue)
);

`default_nettype wire
